// ----- rtl/core/ovle_pkg.sv -----
// Shared constants for the ordered value list engine: field widths,
// command and status codes. No dependencies.
`default_nettype none

package ovle_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 4;
  localparam int HITS_W   = 5;
  localparam int OCC_W    = 5;

  localparam int OUT_FIELDS_W = STATUS_W + 1 + IDX_W + HITS_W + OCC_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/core/ovle_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module ovle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ordered_value_list_engine.sv -----
// Ordered value list engine top level: sequencer around one list RAM.
// Depends on ovle_pkg and ovle_ram.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata: operand_value, tuser: cmd
//  out_     out  out_tvalid/out_tready  tdata: status, found, match_index,
//                                              match_count, occupancy
//
// One item at a time. Append and commands on an empty list go from accept to
// the done state, then into the output register. Find/count walk the list
// through the single RAM read port, one entry a cycle (find stops at the first
// match). Remove writes each later entry one place down as it is read, so it
// too ends at the tail.
// Synchronous active-low reset empties the list; no clearing pass.
// A stalled output holds its item; the next input is taken meanwhile.
`default_nettype none

module ordered_value_list_engine #(
  parameter int DEPTH = ovle_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ovle_pkg::VAL_W-1:0]     in_tdata,   // [31:0] operand_value
  input  wire logic [ovle_pkg::CMD_W-1:0]     in_tuser,   // [1:0] cmd
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [1:0] status, [2] found, [6:3] match_index, [11:7] match_count,
  // [16:12] occupancy, rest zero
  output logic [ovle_pkg::OUT_DATA_W-1:0]     out_tdata
);

  import ovle_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       ra_r, ra_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       pidx_r, pidx_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [VAL_W-1:0]    val_r, val_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_found_r, res_found_nxt;
  logic [CW-1:0]       res_idx_r, res_idx_nxt;
  logic [CW-1:0]       res_hits_r, res_hits_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;
  logic             issue;
  logic             hit;
  logic             walk_done;

  ovle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ra_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // no item is taken while reset is held
  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // read side runs one entry ahead of the compare
  assign issue     = (ra_r < cnt_r);
  assign hit       = pend_r && (ram_rdata == val_r);
  assign walk_done = !pend_r && (ra_r == cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ra_nxt         = ra_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    res_hits_nxt   = res_hits_r;
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_r[AW-1:0];
    ram_wdata      = in_tdata;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (state_r == S_SCAN || state_r == S_SHIFT) begin
      if (issue) begin
        ra_nxt   = ra_r + 1'b1;
        pend_nxt = 1'b1;
        pidx_nxt = ra_r;
      end else begin
        pend_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_tuser;
          val_nxt        = in_tdata;
          res_status_nxt = ST_OK;
          res_found_nxt  = 1'b0;
          res_idx_nxt    = '0;
          res_hits_nxt   = '0;
          ra_nxt         = '0;
          pend_nxt       = 1'b0;
          if (in_tuser == CMD_APPEND) begin
            if (cnt_r == FULL_CNT) begin
              res_status_nxt = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            state_nxt = S_DONE;
          end else if (cnt_r == '0) begin
            res_status_nxt = ST_EMPTY;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (cmd_r == CMD_COUNT) begin
            res_hits_nxt = res_hits_r + 1'b1;
          end else begin
            res_found_nxt = 1'b1;
            res_idx_nxt   = pidx_r;
            // remove: the read of the next entry is already under way
            state_nxt = (cmd_r == CMD_REMOVE) ? S_SHIFT : S_DONE;
          end
        end else if (walk_done) begin
          if (cmd_r != CMD_COUNT) begin
            res_status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pidx_r - 1'b1);
          ram_wdata = ram_rdata;
        end else if (walk_done) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_data_nxt   = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}},
                            OCC_W'(cnt_r), HITS_W'(res_hits_r), IDX_W'(res_idx_r),
                            res_found_r, res_status_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r         <= ra_nxt;
    pidx_r       <= pidx_nxt;
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
    res_hits_r   <= res_hits_nxt;
    out_data_r   <= out_data_nxt;
  end

  // ---------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("list occupancy beyond depth");

  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ram_we)
    else $error("RAM written during search");

  a_shift_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && pend_r) |-> (pidx_r != '0 && pidx_r < cnt_r))
    else $error("compaction write outside list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && walk_done) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("remove did not shrink list by one");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == CMD_APPEND && cnt_r != FULL_CNT)
    |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("append did not grow list by one");

endmodule

`default_nettype wire

// ----- tb/tb_ordered_value_list_engine.sv -----
// Self-checking testbench for ordered_value_list_engine: list predictor and
// result checker in a scoreboard class, stream drivers as plain tasks.
// Depends on ovle_pkg and the engine RTL.
`default_nettype none

module tb_ordered_value_list_engine;
  import ovle_pkg::*;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int PHASE_ITEMS  = 250;
  localparam int HOLD_AT      = 640;
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_REPORTED = 10;

  // packed from the top down, so status lands in the lowest bits
  typedef struct packed {
    logic [OCC_W-1:0]    occupancy;
    logic [HITS_W-1:0]   match_count;
    logic [IDX_W-1:0]    match_index;
    logic                found;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  class list_scoreboard;
    logic [VAL_W-1:0] entries [LIST_DEPTH];
    int               held;
    list_result_t     expected_q [$];
    int               accepted;
    int               checked;
    int               mismatches;
    int               status_seen [4];

    function new();
      held       = 0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // a value currently in the list, so that removes and finds hit
    function logic [VAL_W-1:0] held_value();
      return entries[$urandom_range(held - 1)];
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] val);
      list_result_t r;
      int           pos;
      int           i;
      r        = '0;
      accepted = accepted + 1;
      if (cmd == CMD_APPEND) begin
        if (held >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entries[held] = val;
          held          = held + 1;
        end
      end else if (held == 0) begin
        r.status = ST_EMPTY;
      end else if (cmd == CMD_COUNT) begin
        for (i = 0; i < held; i++)
          if (entries[i] == val) r.match_count = r.match_count + 1'b1;
      end else begin
        pos = held;
        for (i = 0; i < held && pos == held; i++)
          if (entries[i] == val) pos = i;
        if (pos == held) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.found       = 1'b1;
          r.match_index = pos[IDX_W-1:0];
          if (cmd == CMD_REMOVE) begin
            for (i = pos; i + 1 < held; i++) entries[i] = entries[i + 1];
            held = held - 1;
          end
        end
      end
      r.occupancy = held[OCC_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      list_result_t got;
      list_result_t exp_r;
      logic         bad;
      got     = data[OUT_FIELDS_W-1:0];
      checked = checked + 1;
      status_seen[got.status] = status_seen[got.status] + 1;
      if (expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTED)
          $display("unexpected result %0d: tdata=%h with nothing outstanding",
                   checked, data);
        return;
      end
      exp_r = expected_q.pop_front();
      bad   = (got.status != exp_r.status) || (got.found != exp_r.found) ||
              (got.match_index != exp_r.match_index) ||
              (got.match_count != exp_r.match_count) ||
              (got.occupancy != exp_r.occupancy) ||
              (data[OUT_DATA_W-1:OUT_FIELDS_W] != '0);
      if (bad) begin
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTED)
          $display({"result %0d mismatch: exp st=%0d fnd=%0d idx=%0d cnt=%0d occ=%0d",
                    " | got st=%0d fnd=%0d idx=%0d cnt=%0d occ=%0d pad=%h"},
                   checked, exp_r.status, exp_r.found, exp_r.match_index,
                   exp_r.match_count, exp_r.occupancy, got.status, got.found,
                   got.match_index, got.match_count, got.occupancy,
                   data[OUT_DATA_W-1:OUT_FIELDS_W]);
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VAL_W-1:0]      in_tdata  = '0;  // [31:0] operand_value
  logic [CMD_W-1:0]      in_tuser  = CMD_APPEND;  // [1:0] cmd
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [1:0] status, [2] found, [6:3] match_index, [11:7] match_count,
  // [16:12] occupancy, rest zero
  logic [OUT_DATA_W-1:0] out_tdata;

  list_scoreboard sb = new();

  int send_idle_pct = 24;
  int recv_idle_pct = 57;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  logic [VAL_W-1:0] value_pool [6];

  ordered_value_list_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial forever #2 clk = ~clk;

  initial begin
    #2000000;
    $display("[ordered_value_list_engine] ERROR");
    $finish;
  end

  // receiver: random back-pressure plus one long hold-off once the run is deep in
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && sb.accepted >= HOLD_AT) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // called just after a falling edge; returns just after a falling edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, val);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // idle rates change on a rising edge so the receiver reads them race-free
  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 12) return $urandom();
    if (r < 45 && sb.held != 0) return sb.held_value();
    return value_pool[$urandom_range(5)];
  endfunction

  task automatic run_random(input int n_items);
    bit               fill_bias;
    int               seg_left;
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [VAL_W-1:0] val;
    fill_bias = 1'b1;
    seg_left  = 0;
    for (int k = 0; k < n_items; k++) begin
      if (seg_left == 0) begin
        // runs of mostly appends or mostly removes push the list to both ends
        fill_bias = 1'($urandom_range(1));
        seg_left  = $urandom_range(40, 10);
      end
      seg_left = seg_left - 1;
      r = $urandom_range(99);
      if (fill_bias)
        cmd = (r < 55) ? CMD_APPEND : (r < 70) ? CMD_REMOVE :
              (r < 85) ? CMD_FIND : CMD_COUNT;
      else
        cmd = (r < 15) ? CMD_APPEND : (r < 60) ? CMD_REMOVE :
              (r < 80) ? CMD_FIND : CMD_COUNT;
      val = pick_value();
      if (k == n_items / 2) drain_results();  // sender waits for every result
      send_item(cmd, val);
    end
  endtask

  initial begin
    logic [VAL_W-1:0] fill_val;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    value_pool[4] = $urandom();
    // neighbour one bit away, at a random one of the 32 bits, checks that bit in the compare
    value_pool[5] = value_pool[4] ^ (32'h1 << $urandom_range(31));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list, then a single entry in and out again
    send_item(CMD_REMOVE, 32'h0000_0000);
    send_item(CMD_FIND,   32'hFFFF_FFFF);
    send_item(CMD_COUNT,  32'h8000_0000);
    send_item(CMD_APPEND, 32'h8000_0001);
    send_item(CMD_FIND,   32'h8000_0001);
    send_item(CMD_REMOVE, 32'h8000_0001);
    // fill to the brim with extremes and repeats, then overflow
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (i == 0)                   fill_val = 32'h8000_0000;
      else if (i == LIST_DEPTH - 1) fill_val = 32'h7FFF_FFFF;
      else if (i % 3 == 0)          fill_val = 32'hFFFF_FFFF;
      else                          fill_val = i;
      send_item(CMD_APPEND, fill_val);
    end
    send_item(CMD_APPEND, 32'h0000_0000);
    send_item(CMD_FIND,   32'h7FFF_FFFF);
    send_item(CMD_COUNT,  32'hFFFF_FFFF);
    send_item(CMD_REMOVE, 32'h0000_0005);
    send_item(CMD_FIND,   32'h1234_5678);
    drain_results();

    set_idling(24, 57);
    run_random(PHASE_ITEMS);
    drain_results();
    set_idling(57, 24);
    run_random(PHASE_ITEMS);
    drain_results();
    set_idling(0, 0);
    run_random(PHASE_ITEMS);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run covered %0d items and %0d results: ok %0d, empty %0d,",
             sb.accepted, sb.checked, sb.status_seen[ST_OK],
             sb.status_seen[ST_EMPTY]);
    $display("full %0d, not found %0d, mismatches %0d, outstanding %0d",
             sb.status_seen[ST_FULL], sb.status_seen[ST_NOTFOUND],
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[ordered_value_list_engine] OK");
    else
      $display("[ordered_value_list_engine] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/ovle_pkg.sv
rtl/core/ovle_ram.sv
rtl/core/ordered_value_list_engine.sv
tb/tb_ordered_value_list_engine.sv
